[rtl/ltcm_pkg.sv]
package ltcm_pkg;

	localparam int PROB_BITS   = 17;
	localparam int FRAC_BITS   = 16;
	localparam int MAX_RESULTS = 16;
	localparam int LAG_BITS    = 7;
	localparam int STATE_BITS  = 4;

	typedef enum logic [8:0] {
		S_CLR       = 9'b000000001,
		S_IDLE      = 9'b000000010,
		S_FR_SRC    = 9'b000000100,
		S_FR_UPD    = 9'b000001000,
		S_Q_SUM     = 9'b000010000,
		S_Q_SUM_END = 9'b000100000,
		S_Q_RD      = 9'b001000000,
		S_Q_LOAD    = 9'b010000000,
		S_Q_DIV     = 9'b100000000
	} state_t;

endpackage

[rtl/ltcm_ram.sv]
module ltcm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// The read returns the old contents when it hits the address being written.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/ltcm_div.sv]
module ltcm_div
	import ltcm_pkg::*;
#(
	parameter int SW = 36
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 done,
	input  logic [SW-1:0]        num,
	input  logic [SW-1:0]        den,
	output logic [PROB_BITS-1:0] quotient
);

	localparam int STEP_W = $clog2(PROB_BITS);

	logic [SW:0]            rem_q;
	logic [SW-1:0]          den_q;
	logic [PROB_BITS-1:0]   q_q;
	logic [STEP_W-1:0]      step_q;
	logic                   run_q;
	logic                   done_q;
	logic                   ge;
	logic [SW:0]            diff;

	assign ge   = rem_q >= {1'b0, den_q};
	assign diff = ge ? rem_q - {1'b0, den_q} : rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= run_q && (step_q == STEP_W'(PROB_BITS - 1));
			if (start) begin
				run_q <= 1'b1;
			end else if (run_q && (step_q == STEP_W'(PROB_BITS - 1))) begin
				run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= {1'b0, num};
			den_q  <= den;
			q_q    <= '0;
			step_q <= '0;
		end else if (run_q) begin
			rem_q  <= {diff[SW-1:0], 1'b0};
			q_q    <= {q_q[PROB_BITS-2:0], ge};
			step_q <= step_q + 1'b1;
		end
	end

	assign quotient = q_q;
	assign done     = done_q;

endmodule

[rtl/lagged_transition_count_matrix_unit.sv]
// Lagged transition count matrix. A request is taken when start is high and busy is low.
// A frame request runs S_FR_SRC then S_FR_UPD, which is skipped when no transition is
// counted, for the registered read-modify-write of the count memory behind the history
// memory read. A row query first sums the row in S_Q_SUM and S_Q_SUM_END, then steps
// each column through S_Q_RD, S_Q_LOAD and S_Q_DIV on the shared bit-serial divider that
// yields one quotient bit per cycle. Each column result is shown for one cycle under
// result_valid and cannot be held off. After reset a clearing pass over all NUM_STATES *
// NUM_STATES count entries keeps busy high, while writes to lag_frames are still taken.
module lagged_transition_count_matrix_unit
	import ltcm_pkg::*;
#(
	parameter int NUM_STATES = 16,
	parameter int MAX_LAG    = 64,
	parameter int COUNT_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic                  operation,
	input  logic [STATE_BITS-1:0] state_index,
	input  logic                  first_frame,
	input  logic                  lag_frames_we,
	input  logic [LAG_BITS-1:0]   lag_frames,
	output logic                  result_valid,
	output logic [3:0]            column_index,
	output logic [PROB_BITS-1:0]  probability,
	output logic                  count_saturated,
	output logic                  last
);

	localparam int DEPTH = NUM_STATES * NUM_STATES;
	localparam int AW    = $clog2(DEPTH);
	localparam int HW    = (MAX_LAG > 1) ? $clog2(MAX_LAG) : 1;
	localparam int LW    = ($clog2(MAX_LAG + 1) > LAG_BITS) ? $clog2(MAX_LAG + 1) : LAG_BITS;
	localparam int CW    = $clog2(NUM_STATES);
	localparam int SW    = COUNT_BITS + $clog2(NUM_STATES);
	localparam int NR    = (NUM_STATES > MAX_RESULTS) ? MAX_RESULTS : NUM_STATES;

	state_t                state_q;
	logic [LAG_BITS-1:0]   lag_q;
	logic [LW-1:0]         frames_q;
	logic [HW-1:0]         ptr_q;
	logic [AW-1:0]         clr_q;
	logic [STATE_BITS-1:0] s_q;
	logic                  do_q;
	logic                  lag0_q;
	logic [AW-1:0]         cnt_addr_q;
	logic [AW-1:0]         base_q;
	logic [CW-1:0]         col_q;
	logic [SW-1:0]         sum_q;
	logic                  sat_q;
	logic                  result_valid_q;
	logic [3:0]            column_index_q;
	logic [PROB_BITS-1:0]  probability_q;
	logic                  count_saturated_q;
	logic                  last_q;

	logic                  accept;
	logic [LW-1:0]         lag_ext;
	logic [LW-1:0]         lag_eff;
	logic [LW-1:0]         frames_eff;
	logic [LW-1:0]         ptr_ext;
	logic [LW-1:0]         hist_rd_ext;
	logic [HW-1:0]         hist_raddr;
	logic [STATE_BITS-1:0] hist_rdata;
	logic [STATE_BITS-1:0] src;
	logic                  src_ok;
	logic [AW-1:0]         frame_addr;

	logic                  cnt_we;
	logic [AW-1:0]         cnt_waddr;
	logic [COUNT_BITS-1:0] cnt_wdata;
	logic [AW-1:0]         cnt_raddr;
	logic [COUNT_BITS-1:0] cnt_rdata;

	logic                  div_start;
	logic                  div_done;
	logic [PROB_BITS-1:0]  div_q;

	assign busy   = state_q != S_IDLE;
	assign accept = start && !busy;

	assign lag_ext    = LW'(lag_q);
	assign lag_eff    = (lag_ext > LW'(MAX_LAG)) ? LW'(MAX_LAG) : lag_ext;
	assign frames_eff = first_frame ? '0 : frames_q;
	assign ptr_ext    = LW'(ptr_q);
	assign hist_rd_ext = (ptr_ext >= lag_eff) ? ptr_ext - lag_eff
	                                          : ptr_ext + (LW'(MAX_LAG) - lag_eff);
	assign hist_raddr = HW'(hist_rd_ext);

	assign src    = lag0_q ? s_q : hist_rdata;
	assign src_ok = do_q && (32'(src) < NUM_STATES) && (32'(s_q) < NUM_STATES);
	assign frame_addr = AW'(AW'(src) * AW'(NUM_STATES) + AW'(s_q));

	ltcm_ram #(
		.WIDTH (STATE_BITS),
		.DEPTH (MAX_LAG),
		.AW    (HW)
	) u_hist (
		.clk   (clk),
		.we    (accept && !operation),
		.waddr (ptr_q),
		.wdata (state_index),
		.raddr (hist_raddr),
		.rdata (hist_rdata)
	);

	ltcm_ram #(
		.WIDTH (COUNT_BITS),
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_count (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.raddr (cnt_raddr),
		.rdata (cnt_rdata)
	);

	always_comb begin
		cnt_we    = 1'b0;
		cnt_waddr = cnt_addr_q;
		cnt_wdata = (&cnt_rdata) ? cnt_rdata : cnt_rdata + 1'b1;
		cnt_raddr = base_q + AW'(col_q);
		if (state_q == S_CLR) begin
			cnt_we    = 1'b1;
			cnt_waddr = clr_q;
			cnt_wdata = '0;
		end else if (state_q == S_FR_UPD) begin
			cnt_we = 1'b1;
		end else if (state_q == S_FR_SRC) begin
			cnt_raddr = frame_addr;
		end
	end

	assign div_start = state_q == S_Q_LOAD;

	ltcm_div #(
		.SW (SW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.done     (div_done),
		.num      (SW'(cnt_rdata)),
		.den      (sum_q),
		.quotient (div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLR;
			lag_q          <= LAG_BITS'(1);
			frames_q       <= '0;
			ptr_q          <= '0;
			clr_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			if (lag_frames_we) begin
				lag_q <= lag_frames;
			end
			unique case (state_q)
				S_CLR: begin
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
					clr_q <= clr_q + 1'b1;
				end
				S_IDLE: begin
					if (accept && !operation) begin
						frames_q <= (frames_eff < LW'(MAX_LAG)) ? frames_eff + 1'b1 : frames_eff;
						ptr_q    <= (ptr_q == HW'(MAX_LAG - 1)) ? '0 : ptr_q + 1'b1;
						state_q  <= S_FR_SRC;
					end else if (accept && (32'(state_index) < NUM_STATES)) begin
						state_q <= S_Q_SUM;
					end
				end
				S_FR_SRC: begin
					state_q <= src_ok ? S_FR_UPD : S_IDLE;
				end
				S_FR_UPD: begin
					state_q <= S_IDLE;
				end
				S_Q_SUM: begin
					if (col_q == CW'(NUM_STATES - 1)) begin
						state_q <= S_Q_SUM_END;
					end
				end
				S_Q_SUM_END: begin
					state_q <= S_Q_RD;
				end
				S_Q_RD: begin
					state_q <= S_Q_LOAD;
				end
				S_Q_LOAD: begin
					state_q <= S_Q_DIV;
				end
				S_Q_DIV: begin
					if (div_done) begin
						result_valid_q <= 1'b1;
						state_q <= (col_q == CW'(NR - 1)) ? S_IDLE : S_Q_RD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				s_q    <= state_index;
				do_q   <= frames_eff >= lag_eff;
				lag0_q <= lag_eff == '0;
				base_q <= AW'(AW'(state_index) * AW'(NUM_STATES));
				col_q  <= '0;
				sum_q  <= '0;
			end
			S_FR_SRC: begin
				cnt_addr_q <= frame_addr;
			end
			S_Q_SUM: begin
				if (col_q != '0) begin
					sum_q <= sum_q + SW'(cnt_rdata);
				end
				col_q <= (col_q == CW'(NUM_STATES - 1)) ? '0 : col_q + 1'b1;
			end
			S_Q_SUM_END: begin
				sum_q <= sum_q + SW'(cnt_rdata);
			end
			S_Q_LOAD: begin
				sat_q <= &cnt_rdata;
			end
			S_Q_DIV: begin
				if (div_done) begin
					column_index_q    <= 4'(col_q);
					probability_q     <= (sum_q == '0) ? '0 : div_q;
					count_saturated_q <= sat_q;
					last_q            <= col_q == CW'(NR - 1);
					col_q             <= col_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign result_valid    = result_valid_q;
	assign column_index    = column_index_q;
	assign probability     = probability_q;
	assign count_saturated = count_saturated_q;
	assign last            = last_q;

endmodule
